// ===== rtl/diffuse_ray_fan_generator_assert.svh =====
// Assertion macros for the block's modules; drfg_back includes them.
`ifndef DIFFUSE_RAY_FAN_GENERATOR_ASSERT_SVH
`define DIFFUSE_RAY_FAN_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRFG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DRFG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DRFG_ASSERT(label, prop, msg)
`define DRFG_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/drfg_pkg.sv =====
`timescale 1ns / 1ps
package drfg_pkg;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned DVD_W       = 43;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam int unsigned SIN_DEN [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam int unsigned COS_DEN [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  typedef enum logic [3:0] {
    REG_COLS   = 4'd0,
    REG_ROWS   = 4'd1,
    REG_RADIAL = 4'd2,
    REG_AXIAL  = 4'd3,
    REG_WIDTH  = 4'd4,
    REG_HEIGHT = 4'd5,
    REG_Z      = 4'd6,
    REG_WAVE   = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [12:0]        image_cols;
    logic [12:0]        image_rows;
    logic [3:0]         radial_count;
    logic [3:0]         axial_count;
    logic [30:0]        plane_width;
    logic [30:0]        plane_height;
    logic signed [31:0] plane_z;
    logic [31:0]        wave_length;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [7:0]         level;
  } job_t;

  typedef logic signed [31:0] q30_tab_t [64];
  typedef logic signed [15:0] q15_tab_t [64];

  // Divide by a step count of 1..8 (literal divisors only).
  function automatic logic [63:0] div_small(input logic [63:0] x, input logic [3:0] n);
    logic [63:0] res;
    case (n)
      4'd2: res = x / 2;
      4'd3: res = x / 3;
      4'd4: res = x / 4;
      4'd5: res = x / 5;
      4'd6: res = x / 6;
      4'd7: res = x / 7;
      4'd8: res = x / 8;
      default: res = x;
    endcase
    return res;
  endfunction

  // Taylor sine and cosine on [0, pi/2), Q2.30; returns {sin, cos}.
  function automatic logic [63:0] sin_cos_q30(input logic [63:0] t);
    logic [63:0]        t2, ts, tc;
    logic signed [63:0] s_acc, c_acc;
    t2    = (t * t) >> 30;
    ts    = t;
    tc    = ONE_Q30;
    s_acc = signed'(t);
    c_acc = signed'(ONE_Q30);
    for (int k = 0; k < 8; k++) begin
      ts = ((ts * t2) >> 30) / SIN_DEN[k];
      tc = ((tc * t2) >> 30) / COS_DEN[k];
      if ((k & 1) == 0) begin
        s_acc = s_acc - signed'(ts);
        c_acc = c_acc - signed'(tc);
      end else begin
        s_acc = s_acc + signed'(ts);
        c_acc = c_acc + signed'(tc);
      end
    end
    return {s_acc[31:0], c_acc[31:0]};
  endfunction

  // Round to nearest with ties away from zero, then saturate to Q1.15.
  function automatic logic signed [15:0] round_sat16(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic [63:0]        mag, rr, neg;
    logic signed [15:0] res;
    mag = v[63] ? (64'd0 - v) : v;
    rr  = (mag + (64'd1 << (sh - 1))) >> sh;
    if (rr > 64'd32768) rr = 64'd32768;
    neg = 64'd0 - rr;
    if (v[63]) res = neg[15:0];
    else if (rr > 64'd32767) res = 16'sd32767;
    else res = rr[15:0];
    return res;
  endfunction

  // Index {count-1, step}: polar angle tables.
  function automatic q30_tab_t build_theta_s();
    q30_tab_t    tab;
    logic [5:0]  ix;
    logic [63:0] sc;
    for (int i = 0; i < 64; i++) begin
      ix     = 6'(i);
      sc     = sin_cos_q30(div_small(64'(ix[2:0]) * HALF_PI_Q30, {1'b0, ix[5:3]} + 4'd1));
      tab[i] = sc[63:32];
    end
    return tab;
  endfunction

  function automatic q15_tab_t build_dir_z();
    q15_tab_t    tab;
    logic [5:0]  ix;
    logic [63:0] sc;
    for (int i = 0; i < 64; i++) begin
      ix     = 6'(i);
      sc     = sin_cos_q30(div_small(64'(ix[2:0]) * HALF_PI_Q30, {1'b0, ix[5:3]} + 4'd1));
      tab[i] = round_sat16(64'(signed'(sc[31:0])), 15);
    end
    return tab;
  endfunction

  // Azimuth tables with quadrant folding; sel_cos picks cos phi, else sin phi.
  function automatic q30_tab_t build_phi(input logic sel_cos);
    q30_tab_t           tab;
    logic [5:0]         ix;
    logic [3:0]         n;
    logic [63:0]        q4, quo, rem, sc;
    logic signed [31:0] s0, c0, sp, cp;
    for (int i = 0; i < 64; i++) begin
      ix  = 6'(i);
      n   = {1'b0, ix[5:3]} + 4'd1;
      q4  = 64'(ix[2:0]) * 64'd4;
      quo = div_small(q4, n);
      rem = q4 - quo * 64'(n);
      sc  = sin_cos_q30(div_small(rem * HALF_PI_Q30, n));
      s0  = sc[63:32];
      c0  = sc[31:0];
      case (quo[1:0])
        2'd0: begin sp = s0;  cp = c0;  end
        2'd1: begin sp = c0;  cp = -s0; end
        2'd2: begin sp = -s0; cp = -c0; end
        default: begin sp = -c0; cp = s0; end
      endcase
      tab[i] = sel_cos ? cp : sp;
    end
    return tab;
  endfunction

  localparam q30_tab_t THETA_S = build_theta_s();
  localparam q15_tab_t DIR_Z   = build_dir_z();
  localparam q30_tab_t PHI_C   = build_phi(1'b1);
  localparam q30_tab_t PHI_S   = build_phi(1'b0);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_DONE} front_state_e;
  typedef enum logic [1:0] {B_IDLE, B_LOOK, B_MUL, B_EMIT} back_state_e;

endpackage

// ===== rtl/diffuse_ray_fan_generator.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// cfg       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
// in        in_valid_i / in_ready_o     pixel_col_i, pixel_row_i, pixel_level_i
// out       out_valid_o / out_ready_i   origin_*, dir_*, ray_wavelength_o, ray_level_o, last_ray_o
//
// In the front end a pixel item forms its products on acceptance, then runs the
// bit-serial restoring divider that maps column and row in parallel, then hands off.
// The back end steps through table read, multiply and round for each ray; the two-entry
// queue lets the front work on the next pixels meanwhile.
// Reset clears all control state and sets the registers to their defaults; no clear pass.
// A stalled output holds the ray in the output register and freezes the back end.
module diffuse_ray_fan_generator
  import drfg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        pixel_col_i,
  input  logic [11:0]        pixel_row_i,
  input  logic [7:0]         pixel_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] origin_x_o,
  output logic signed [31:0] origin_y_o,
  output logic signed [31:0] origin_z_o,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic signed [15:0] dir_z_o,
  output logic [31:0]        ray_wavelength_o,
  output logic [7:0]         ray_level_o,
  output logic               last_ray_o
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_cols   <= 13'd1;
      cfg_q.image_rows   <= 13'd1;
      cfg_q.radial_count <= 4'd1;
      cfg_q.axial_count  <= 4'd1;
      cfg_q.plane_width  <= '0;
      cfg_q.plane_height <= '0;
      cfg_q.plane_z      <= '0;
      cfg_q.wave_length  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COLS:   cfg_q.image_cols   <= cfg_data_i[12:0];
        REG_ROWS:   cfg_q.image_rows   <= cfg_data_i[12:0];
        REG_RADIAL: cfg_q.radial_count <= cfg_data_i[3:0];
        REG_AXIAL:  cfg_q.axial_count  <= cfg_data_i[3:0];
        REG_WIDTH:  cfg_q.plane_width  <= cfg_data_i[30:0];
        REG_HEIGHT: cfg_q.plane_height <= cfg_data_i[30:0];
        REG_Z:      cfg_q.plane_z      <= cfg_data_i;
        REG_WAVE:   cfg_q.wave_length  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accept the pixel and compute its origin.
  drfg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_level_i (pixel_level_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .job_o         (push_job)
  );

  // Decouple the divider from the ray sequencer.
  drfg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  // Back: walk the angle grid and emit one ray per step.
  drfg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .job_valid_i      (pop_valid),
    .job_ready_o      (pop_ready),
    .job_i            (pop_job),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .origin_x_o       (origin_x_o),
    .origin_y_o       (origin_y_o),
    .origin_z_o       (origin_z_o),
    .dir_x_o          (dir_x_o),
    .dir_y_o          (dir_y_o),
    .dir_z_o          (dir_z_o),
    .ray_wavelength_o (ray_wavelength_o),
    .ray_level_o      (ray_level_o),
    .last_ray_o       (last_ray_o)
  );

endmodule

// ===== rtl/drfg_front.sv =====
`timescale 1ns / 1ps
module drfg_front
  import drfg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] pixel_col_i,
  input  logic [11:0] pixel_row_i,
  input  logic [7:0]  pixel_level_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output job_t        job_o
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    else res = v;
    return res;
  endfunction

  // q - span/2, saturated high (q is never negative)
  function automatic logic signed [31:0] map_sat(input logic [DVD_W-1:0] q,
                                                 input logic [30:0] span);
    logic signed [DVD_W+1:0] diff;
    diff = signed'({2'b00, q}) - signed'((DVD_W+2)'(span >> 1));
    if (diff > signed'((DVD_W+2)'(32'h7fffffff))) return 32'sh7fffffff;
    return diff[31:0];
  endfunction

  front_state_e     state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_x_q, dvd_x_d, dvd_y_q, dvd_y_d;
  logic [DIM_W-1:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [7:0]       lvl_q, lvl_d;
  logic [DIM_W-1:0] div_x, div_y;
  logic [DIM_W:0]   sh_x, sh_y;
  logic             ge_x, ge_y;

  assign div_x = clamp_dim(cfg_i.image_cols);
  assign div_y = clamp_dim(cfg_i.image_rows);
  assign sh_x  = {rem_x_q, dvd_x_q[DVD_W-1]};
  assign sh_y  = {rem_y_q, dvd_y_q[DVD_W-1]};
  assign ge_x  = sh_x >= {1'b0, div_x};
  assign ge_y  = sh_y >= {1'b0, div_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_x_q <= dvd_x_d;
    dvd_y_q <= dvd_y_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    lvl_q   <= lvl_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    dvd_x_d      = dvd_x_q;
    dvd_y_d      = dvd_y_q;
    rem_x_d      = rem_x_q;
    rem_y_d      = rem_y_q;
    lvl_d        = lvl_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dvd_x_d = DVD_W'(pixel_col_i) * DVD_W'(cfg_i.plane_width);
          dvd_y_d = DVD_W'(pixel_row_i) * DVD_W'(cfg_i.plane_height);
          rem_x_d = '0;
          rem_y_d = '0;
          lvl_d   = pixel_level_i;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // restoring step: quotient bits shift in where dividend bits leave
        rem_x_d = ge_x ? DIM_W'(sh_x - {1'b0, div_x}) : DIM_W'(sh_x);
        rem_y_d = ge_y ? DIM_W'(sh_y - {1'b0, div_y}) : DIM_W'(sh_y);
        dvd_x_d = {dvd_x_q[DVD_W-2:0], ge_x};
        dvd_y_d = {dvd_y_q[DVD_W-2:0], ge_y};
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == 6'(DVD_W - 1)) state_d = F_DONE;
      end
      F_DONE: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o.origin_x = map_sat(dvd_x_q, cfg_i.plane_width);
  assign job_o.origin_y = map_sat(dvd_y_q, cfg_i.plane_height);
  assign job_o.level    = lvl_q;

endmodule

// ===== rtl/drfg_queue.sv =====
`timescale 1ns / 1ps
module drfg_queue
  import drfg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t       mem_q [QUEUE_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/drfg_back.sv =====
`timescale 1ns / 1ps
`include "diffuse_ray_fan_generator_assert.svh"
module drfg_back
  import drfg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  job_t               job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] origin_x_o,
  output logic signed [31:0] origin_y_o,
  output logic signed [31:0] origin_z_o,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic signed [15:0] dir_z_o,
  output logic [31:0]        ray_wavelength_o,
  output logic [7:0]         ray_level_o,
  output logic               last_ray_o
);

  // step count minus one, clamped to 1..8
  function automatic logic [2:0] steps_m1(input logic [3:0] v);
    logic [2:0] res;
    if (v == 4'd0) res = 3'd0;
    else if (v > 4'd8) res = 3'd7;
    else res = 3'(v - 4'd1);
    return res;
  endfunction

  back_state_e        state_q, state_d;
  logic [2:0]         r_q, r_d, a_q, a_d;
  logic [2:0]         nr_m1, na_m1;
  logic               last;
  logic               load_out;
  job_t               job_q;
  logic signed [31:0] st_q, cp_q, sp_q;
  logic signed [15:0] dz_q;
  logic signed [63:0] px_q, py_q;
  logic               out_valid_q;

  assign nr_m1 = steps_m1(cfg_i.radial_count);
  assign na_m1 = steps_m1(cfg_i.axial_count);
  assign last  = (r_q == nr_m1) && (a_q == na_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      r_q         <= '0;
      a_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      a_q     <= a_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) job_q <= job_i;
    if (state_q == B_LOOK) begin
      st_q <= THETA_S[{nr_m1, r_q}];
      dz_q <= DIR_Z[{nr_m1, r_q}];
      cp_q <= PHI_C[{na_m1, a_q}];
      sp_q <= PHI_S[{na_m1, a_q}];
    end
    if (state_q == B_MUL) begin
      px_q <= st_q * cp_q;
      py_q <= st_q * sp_q;
    end
    if (load_out) begin
      origin_x_o       <= job_q.origin_x;
      origin_y_o       <= job_q.origin_y;
      origin_z_o       <= cfg_i.plane_z;
      dir_x_o          <= round_sat16(px_q, 45);
      dir_y_o          <= round_sat16(py_q, 45);
      dir_z_o          <= dz_q;
      ray_wavelength_o <= cfg_i.wave_length;
      ray_level_o      <= job_q.level;
      last_ray_o       <= last;
    end
  end

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    a_d         = a_q;
    job_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      B_IDLE: begin
        job_ready_o = 1'b1;
        r_d         = '0;
        a_d         = '0;
        if (job_valid_i) state_d = B_LOOK;
      end
      B_LOOK: state_d = B_MUL;
      B_MUL:  state_d = B_EMIT;
      B_EMIT: begin
        // hold until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (last) begin
            r_d     = '0;
            a_d     = '0;
            state_d = B_IDLE;
          end else begin
            if (a_q == na_m1) begin
              a_d = '0;
              r_d = r_q + 3'd1;
            end else begin
              a_d = a_q + 3'd1;
            end
            state_d = B_LOOK;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `DRFG_ASSERT(idle_counters_clear, (state_q == B_IDLE) |-> (r_q == 3'd0 && a_q == 3'd0), "counters not clear in idle")
  `DRFG_ASSERT(last_ray_ends_pixel, (load_out && last) |=> (state_q == B_IDLE), "pixel did not end on last ray")
  `DRFG_ASSERT_NEVER(step_past_count, (state_q != B_IDLE) && (r_q > nr_m1 || a_q > na_m1), "step index beyond count")

endmodule
